FILE: hdl/assert_macros.svh
// Assertion macros used by the top level of the transposition table.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds at every clock edge outside reset.
`define ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: hdl/ttps_pkg.sv
// Types, codes and score constants of the transposition table.
// No dependencies.
package ttps_pkg;

    localparam int KEY_W   = 64;
    localparam int DEPTH_W = 8;
    localparam int SCORE_W = 18;
    localparam int BOUND_W = 2;

    // Index reduction for tables whose size is not a power of two
    localparam int DIV_DIGIT = 4;
    localparam int DIV_STEPS = KEY_W / DIV_DIGIT;

    localparam logic KIND_PROBE = 1'b0;
    localparam logic KIND_STORE = 1'b1;

    localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
    localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd1;
    localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd2;

    // Draw, mate and loss scores that are never trusted from the table
    localparam logic signed [SCORE_W-1:0] SCORE_MATE_NEG  = -18'sd80088;
    localparam logic signed [SCORE_W-1:0] SCORE_LOSS_NEG  = -18'sd80060;
    localparam logic signed [SCORE_W-1:0] SCORE_MATE_POS  = 18'sd80088;
    localparam logic signed [SCORE_W-1:0] SCORE_LOSS_POS  = 18'sd80060;
    localparam logic signed [SCORE_W-1:0] SCORE_DRAW_POS  = 18'sd66666;
    localparam logic signed [SCORE_W-1:0] SCORE_DRAW_NEG  = -18'sd66666;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic [DEPTH_W-1:0]        depth;
        logic signed [SCORE_W-1:0] score;
        logic [BOUND_W-1:0]        bound;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic                      kind;
        logic [KEY_W-1:0]          position_key;
        logic [DEPTH_W-1:0]        search_depth;
        logic signed [SCORE_W-1:0] entry_value;
        logic [BOUND_W-1:0]        bound_type;
        logic signed [SCORE_W-1:0] alpha_bound;
        logic signed [SCORE_W-1:0] beta_bound;
    } t_item;

    function automatic logic is_special(input logic signed [SCORE_W-1:0] s);
        return (s == SCORE_MATE_NEG) || (s == SCORE_LOSS_NEG) ||
               (s == SCORE_MATE_POS) || (s == SCORE_LOSS_POS) ||
               (s == SCORE_DRAW_POS) || (s == SCORE_DRAW_NEG);
    endfunction

endpackage

FILE: hdl/ttps_if.sv
// Valid/ready channel interfaces for probe/store requests and results.
// Depends on ttps_pkg for field widths.
interface ttps_in_if import ttps_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [KEY_W-1:0]          position_key;
    logic [DEPTH_W-1:0]        search_depth;
    logic signed [SCORE_W-1:0] entry_value;
    logic [BOUND_W-1:0]        bound_type;
    logic signed [SCORE_W-1:0] alpha_bound;
    logic signed [SCORE_W-1:0] beta_bound;

    modport source (
        output valid, kind, position_key, search_depth, entry_value,
               bound_type, alpha_bound, beta_bound,
        input  ready
    );
    modport sink (
        input  valid, kind, position_key, search_depth, entry_value,
               bound_type, alpha_bound, beta_bound,
        output ready
    );
endinterface

interface ttps_out_if import ttps_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      hit;
    logic signed [SCORE_W-1:0] found_value;

    modport source (output valid, hit, found_value, input ready);
    modport sink (input valid, hit, found_value, output ready);
endinterface

FILE: hdl/ttps_ram.sv
// Generic single-write, single-read RAM with a registered, read-first output.
// No dependencies.
module ttps_ram #(
    parameter int WIDTH = 92,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/transposition_table_probe_store.sv
// Channel   Dir  Modport  Payload
// i_in      in   sink     kind, position_key, search_depth, entry_value,
//                         bound_type, alpha_bound, beta_bound
// o_out     out  source   hit, found_value
//
// Power-of-two table size: one transfer per cycle unless the output stalls;
// each item passes entry read, compare and write back, and result register.
// Other sizes: the key is reduced to an index four bits a cycle. After reset
// a clearing pass writes TABLE_ENTRIES zero entries, one a cycle, before the
// first input transfer. A stalled result holds the compare stage, which
// holds input ready low; reads are issued only when that stage frees.
// Top level of the direct-mapped transposition table.
// Depends on ttps_pkg, ttps_if, ttps_ram and assert_macros.svh.
`include "assert_macros.svh"

module transposition_table_probe_store import ttps_pkg::*; #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ttps_in_if.sink     i_in,
    ttps_out_if.source  o_out
);

    localparam int  IDX_W    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam bit  IS_POW2  = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        S_CLEAR = 2'b01,
        S_RUN   = 2'b10
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_clr_idx;

    // Request into the read stage
    logic             req_valid;
    logic             req_ready;
    logic             req_fire;
    t_item            req_item;
    logic [IDX_W-1:0] req_idx;

    // Compare / write-back stage
    logic             r_s1_valid;
    t_item            r_s1_item;
    logic [IDX_W-1:0] r_s1_idx;
    logic             s1_adv;
    logic             s1_we;

    logic [ENTRY_W-1:0] ram_rdata;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;

    logic   r_fwd_valid;
    t_entry r_fwd_entry;
    t_entry cur_entry;
    t_entry new_entry;

    logic key_match;
    logic special;
    logic probe_hit;
    logic keep_entry;

    logic                      r_out_valid;
    logic                      r_out_hit;
    logic signed [SCORE_W-1:0] r_out_value;

    // ------------------------------------------------------------------
    // Index generation
    // ------------------------------------------------------------------
    generate
        if (IS_POW2) begin : g_mask
            // Index is the low key bits; the request is the input itself.
            assign req_valid  = i_in.valid;
            assign i_in.ready = req_ready;
            assign req_idx    = i_in.position_key[IDX_W-1:0];
            assign req_item   = '{kind:         i_in.kind,
                                  position_key: i_in.position_key,
                                  search_depth: i_in.search_depth,
                                  entry_value:  i_in.entry_value,
                                  bound_type:   i_in.bound_type,
                                  alpha_bound:  i_in.alpha_bound,
                                  beta_bound:   i_in.beta_bound};
        end else begin : g_reduce
            // Reduce the key modulo the table size, MSB first, one digit a cycle.
            typedef enum logic [2:0] {
                D_IDLE = 3'b001,
                D_RUN  = 3'b010,
                D_DONE = 3'b100
            } t_div_state;

            localparam int CNT_W = $clog2(DIV_STEPS);
            localparam logic [IDX_W:0] N_EXT = (IDX_W + 1)'(TABLE_ENTRIES);

            t_div_state       r_div_state;
            t_item            r_div_item;
            logic [KEY_W-1:0] r_div_shift;
            logic [IDX_W-1:0] r_div_rem;
            logic [CNT_W-1:0] r_div_cnt;
            logic [IDX_W-1:0] n_div_rem;

            always_comb begin
                logic [IDX_W:0]   t;
                logic [IDX_W-1:0] rem;
                rem = r_div_rem;
                for (int j = 0; j < DIV_DIGIT; j++) begin
                    t = {rem, r_div_shift[KEY_W-1-j]};
                    if (t >= N_EXT) begin
                        t = t - N_EXT;
                    end
                    rem = t[IDX_W-1:0];
                end
                n_div_rem = rem;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_div_state <= D_IDLE;
                end else begin
                    unique case (r_div_state)
                        D_IDLE: begin
                            if (i_in.valid && i_in.ready) begin
                                r_div_state <= D_RUN;
                            end
                        end
                        D_RUN: begin
                            if (r_div_cnt == CNT_W'(DIV_STEPS - 1)) begin
                                r_div_state <= D_DONE;
                            end
                        end
                        D_DONE: begin
                            if (req_ready) begin
                                r_div_state <= D_IDLE;
                            end
                        end
                        default: r_div_state <= D_IDLE;
                    endcase
                end
            end

            always_ff @(posedge i_clk) begin
                if (r_div_state == D_IDLE) begin
                    r_div_item  <= '{kind:         i_in.kind,
                                     position_key: i_in.position_key,
                                     search_depth: i_in.search_depth,
                                     entry_value:  i_in.entry_value,
                                     bound_type:   i_in.bound_type,
                                     alpha_bound:  i_in.alpha_bound,
                                     beta_bound:   i_in.beta_bound};
                    r_div_shift <= i_in.position_key;
                    r_div_rem   <= '0;
                    r_div_cnt   <= '0;
                end else if (r_div_state == D_RUN) begin
                    r_div_shift <= r_div_shift << DIV_DIGIT;
                    r_div_rem   <= n_div_rem;
                    r_div_cnt   <= r_div_cnt + 1'b1;
                end
            end

            assign i_in.ready = (r_div_state == D_IDLE) && (r_state == S_RUN);
            assign req_valid  = (r_div_state == D_DONE);
            assign req_idx    = r_div_rem;
            assign req_item   = r_div_item;
        end
    endgenerate

    // ------------------------------------------------------------------
    // Read stage: issue the entry read when the compare stage frees up
    // ------------------------------------------------------------------
    assign s1_adv    = r_s1_valid && (!r_out_valid || o_out.ready);
    assign req_ready = (r_state == S_RUN) && (!r_s1_valid || s1_adv);
    assign req_fire  = req_valid && req_ready;

    ttps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (req_fire),
        .i_raddr (req_idx),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Compare stage
    // ------------------------------------------------------------------
    // The RAM returns old data when the previous store writes the same entry
    // in the cycle of the read; take the written entry instead.
    assign cur_entry = r_fwd_valid ? r_fwd_entry : t_entry'(ram_rdata);

    assign key_match = (cur_entry.key == r_s1_item.position_key);
    assign special   = is_special(cur_entry.score);

    always_comb begin
        probe_hit = 1'b0;
        if (key_match && (cur_entry.depth >= r_s1_item.search_depth) && !special) begin
            unique case (cur_entry.bound)
                BOUND_EXACT: probe_hit = 1'b1;
                BOUND_LOWER: probe_hit = (cur_entry.score >= r_s1_item.beta_bound);
                BOUND_UPPER: probe_hit = (cur_entry.score <= r_s1_item.alpha_bound);
                default:     probe_hit = 1'b0;
            endcase
        end
    end

    // Keep a deeper result for the same position unless its score is special.
    assign keep_entry = key_match && (cur_entry.depth > r_s1_item.search_depth) && !special;
    assign s1_we      = s1_adv && (r_s1_item.kind == KIND_STORE) && !keep_entry;

    assign new_entry = '{key:   r_s1_item.position_key,
                         depth: r_s1_item.search_depth,
                         score: r_s1_item.entry_value,
                         bound: r_s1_item.bound_type};

    // Clearing pass owns the write port until it finishes.
    assign ram_we    = (r_state == S_CLEAR) || s1_we;
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr_idx : r_s1_idx;
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : ENTRY_W'(new_entry);

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Sweep the table to zero, one entry a cycle
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr_idx == LAST_IDX) begin
                        r_state <= S_RUN;
                    end else begin
                        r_clr_idx <= r_clr_idx + 1'b1;
                    end
                end
                S_RUN:   r_state <= S_RUN;
                default: r_state <= S_CLEAR;
            endcase

            // Advance or drain the compare stage
            if (req_fire) begin
                r_s1_valid  <= 1'b1;
                r_fwd_valid <= s1_we && (req_idx == r_s1_idx);
            end else if (s1_adv) begin
                r_s1_valid  <= 1'b0;
                r_fwd_valid <= 1'b0;
            end

            // Output register: load on advance, drop on transfer
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_s1_item   <= req_item;
            r_s1_idx    <= req_idx;
            r_fwd_entry <= new_entry;
        end
        if (s1_adv) begin
            r_out_hit   <= (r_s1_item.kind == KIND_PROBE) && probe_hit;
            r_out_value <= ((r_s1_item.kind == KIND_PROBE) && probe_hit) ?
                           cur_entry.score : '0;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.hit         = r_out_hit;
    assign o_out.found_value = r_out_value;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPLY(a_no_transfer_in_clear, i_in.valid && i_in.ready, r_state == S_RUN, "input transfer during clearing pass")
    `ASSERT_IMPLY(a_fwd_has_item, r_fwd_valid, r_s1_valid, "forwarded entry without an item in the compare stage")
    `ASSERT_NEVER(a_write_in_clear, s1_we && (r_state == S_CLEAR), "store write-back during clearing pass")
    `ASSERT_IMPLY(a_miss_zero, o_out.valid && !o_out.hit, o_out.found_value == '0, "miss carries a nonzero value")

endmodule
